// File: rtl/core/tmlc_pkg.sv
// Shared types and constants for the truncated mean layer charge block.
`timescale 1ns / 1ps
`default_nettype none
package tmlc_pkg;
  localparam int SumW    = 23;
  localparam int ChargeW = 16;
  localparam int FracW   = 9;
  localparam int CntOutW = 8;
  localparam logic [SumW-1:0]  SumMax      = {SumW{1'b1}};
  localparam logic [FracW-1:0] FractionOne = 9'd256;
  localparam logic [FracW-1:0] ThreshReset = 9'd1;
  localparam logic [FracW-1:0] FracReset   = 9'd179;

  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_FRACTION  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic accept;
    logic keep_calc;
    logic scan_init;
    logic scan_run;
    logic acc;
    logic div_init;
    logic div_run;
    logic load_out;
  } tmlc_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic scan_done;
    logic div_last;
    logic out_free;
  } tmlc_status_t;
endpackage
`default_nettype wire

// File: rtl/core/tmlc_ctrl.sv
// Sequencer for pad intake, sum selection passes, division and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module tmlc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  end_of_event,
  output logic                       in_stall,
  output tmlc_pkg::tmlc_cmd_t        cmd,
  input  wire tmlc_pkg::tmlc_status_t status
);
  import tmlc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_KEEP  = 8'b0000_0010,
    S_CHECK = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_DIVI  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && end_of_event) state_next = S_KEEP;
      end
      S_KEEP: begin
        cmd.keep_calc = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        if (status.rem_zero) begin
          state_next = S_DIVI;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_CHECK;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (status.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/tmlc_datapath.sv
// Layer summing, sum store, smallest-sum selection, divider and output register.
`timescale 1ns / 1ps
`default_nettype none
module tmlc_datapath #(
  parameter int MAX_LAYERS = 128
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [15:0]           cfg_data,
  input  wire logic [15:0]           pad_charge,
  input  wire logic                  end_of_layer,
  input  wire logic                  end_of_event,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [22:0]                truncated_mean,
  output logic [7:0]                 layers_used,
  output logic [7:0]                 layers_kept,
  output logic                       empty_result,
  output logic                       layer_overflow,
  input  wire tmlc_pkg::tmlc_cmd_t   cmd,
  output tmlc_pkg::tmlc_status_t     status
);
  import tmlc_pkg::*;

  localparam int AW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CW  = $clog2(MAX_LAYERS + 1);
  localparam int SW  = SumW + CW;
  localparam int DW  = SW + 3;
  localparam int RW  = CW + 4;
  localparam int STW = $clog2(DW);
  localparam logic [CW-1:0]  MaxCnt  = CW'(MAX_LAYERS);
  localparam logic [STW-1:0] LastStep = STW'(DW - 1);

  // configuration
  logic [ChargeW-1:0] threshold;
  logic [FracW-1:0]   fraction;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ChargeW'(ThreshReset);
      fraction  <= FracReset;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_THRESHOLD: threshold <= cfg_data;
        REG_FRACTION:  fraction  <= cfg_data[FracW-1:0];
        default: ;
      endcase
    end
  end

  // layer summing
  logic [SumW-1:0] run_sum;
  logic [CW-1:0]   cnt;
  logic            ovf;
  logic [SumW:0]   add_wide;
  logic [SumW-1:0] eff_sum;
  logic            close;
  logic            mem_we;

  assign add_wide = {1'b0, run_sum} +
                    ((pad_charge >= threshold) ? (SumW+1)'(pad_charge) : '0);
  assign eff_sum  = add_wide[SumW] ? SumMax : add_wide[SumW-1:0];
  assign close    = cmd.accept && (end_of_layer || end_of_event);
  assign mem_we   = close && (eff_sum != '0) && (cnt < MaxCnt);

  logic [SumW-1:0] mem [MAX_LAYERS];
  logic [SumW-1:0] rdata;
  logic [CW-1:0]   idx;

  always_ff @(posedge clk) begin
    if (mem_we) mem[cnt[AW-1:0]] <= eff_sum;
    rdata <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum <= '0;
      cnt     <= '0;
      ovf     <= 1'b0;
    end else begin
      if (cmd.accept) run_sum <= close ? '0 : eff_sum;
      if (mem_we) cnt <= cnt + 1'b1;
      else if (close && eff_sum != '0) ovf <= 1'b1;
      if (cmd.load_out) begin
        cnt <= '0;
        ovf <= 1'b0;
      end
    end
  end

  // selection: each pass finds the smallest sum above the previous one and its count
  logic [FracW-1:0]    frac_c;
  logic [CW+FracW-1:0] kept_prod;
  logic [CW-1:0]       kept, rem, min_cnt, take;
  logic [SumW-1:0]     prev, min_val;
  logic                found, rv;
  logic [SW-1:0]       total;
  logic [CW+SumW-1:0]  prod;

  assign frac_c    = (fraction > FractionOne) ? FractionOne : fraction;
  assign kept_prod = (CW+FracW)'(cnt) * (CW+FracW)'(frac_c);
  assign take      = (min_cnt < rem) ? min_cnt : rem;
  assign prod      = (CW+SumW)'(take) * (CW+SumW)'(min_val);

  always_ff @(posedge clk) begin
    if (cmd.keep_calc) begin
      kept  <= kept_prod[CW+7:8];
      rem   <= kept_prod[CW+7:8];
      prev  <= '0;
      total <= '0;
    end
    if (cmd.scan_init) begin
      idx   <= '0;
      rv    <= 1'b0;
      found <= 1'b0;
    end
    if (cmd.scan_run) begin
      rv <= (idx != cnt);
      if (idx != cnt) idx <= idx + 1'b1;
      if (rv && rdata > prev) begin
        if (!found || rdata < min_val) begin
          min_val <= rdata;
          min_cnt <= CW'(1);
          found   <= 1'b1;
        end else if (rdata == min_val) begin
          min_cnt <= min_cnt + 1'b1;
        end
      end
    end
    if (cmd.acc) begin
      if (found) begin
        total <= total + SW'(prod);
        rem   <= rem - take;
        prev  <= min_val;
      end else begin
        rem <= '0;
      end
    end
  end

  // restoring divider: 5*total / (6*kept)
  logic [DW-1:0]   quo;
  logic [RW-1:0]   rmd, rmd_sh;
  logic [CW+2:0]   divisor;
  logic [STW-1:0]  step;

  assign divisor = {1'b0, kept, 2'b00} + {2'b00, kept, 1'b0};
  assign rmd_sh  = {rmd[RW-2:0], quo[DW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo  <= {1'b0, total, 2'b00} + {3'b000, total};
      rmd  <= '0;
      step <= '0;
    end else if (cmd.div_run) begin
      step <= step + 1'b1;
      if (rmd_sh >= RW'(divisor)) begin
        rmd <= rmd_sh - RW'(divisor);
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rmd <= rmd_sh;
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

  // output register
  logic [CW+CntOutW-1:0] used_ext, kept_ext;
  assign used_ext = {{CntOutW{1'b0}}, cnt};
  assign kept_ext = {{CntOutW{1'b0}}, kept};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      truncated_mean <= (kept == '0) ? '0 : quo[SumW-1:0];
      layers_used    <= used_ext[CntOutW-1:0];
      layers_kept    <= kept_ext[CntOutW-1:0];
      empty_result   <= (kept == '0);
      layer_overflow <= ovf;
    end
  end

  assign status.rem_zero  = (rem == '0);
  assign status.scan_done = (idx == cnt) && !rv;
  assign status.div_last  = (step == LastStep);
  assign status.out_free  = !out_valid || !out_stall;
endmodule
`default_nettype wire

// File: rtl/core/truncated_mean_layer_charge.sv
// Top level of the truncated mean layer charge block.
//
// Pads are taken one per cycle while idle; layers with a nonzero thresholded
// sum go into an on-chip store of MAX_LAYERS entries. After the end-of-event
// transaction the input stalls while the kept smallest sums are gathered in
// passes over the store (one pass per distinct kept value, each pass a scan
// through the single store read port plus a check and an accumulate step),
// then a restoring divider, after a set-up step, yields one quotient bit per
// cycle. A finished result sits in the output register until taken; the
// input resumes when it is loaded, once any earlier result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module truncated_mean_layer_charge #(
  parameter int MAX_LAYERS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] pad_charge,
  input  wire logic        end_of_layer,
  input  wire logic        end_of_event,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [22:0]      truncated_mean,
  output logic [7:0]       layers_used,
  output logic [7:0]       layers_kept,
  output logic             empty_result,
  output logic             layer_overflow
);
  import tmlc_pkg::*;

  tmlc_cmd_t    cmd;
  tmlc_status_t status;

  tmlc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .end_of_event (end_of_event),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .status       (status)
  );

  tmlc_datapath #(.MAX_LAYERS(MAX_LAYERS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pad_charge     (pad_charge),
    .end_of_layer   (end_of_layer),
    .end_of_event   (end_of_event),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .truncated_mean (truncated_mean),
    .layers_used    (layers_used),
    .layers_kept    (layers_kept),
    .empty_result   (empty_result),
    .layer_overflow (layer_overflow),
    .cmd            (cmd),
    .status         (status)
  );
endmodule
`default_nettype wire
